@@ sv/fat_cluster_chain_allocator_core_defines.svh @@
// Assertion macros for the FAT cluster chain allocator.
// Used by the top level, which supplies clk_i and rst_ni in scope.
`ifndef FAT_CLUSTER_CHAIN_ALLOCATOR_CORE_DEFINES_SVH
`define FAT_CLUSTER_CHAIN_ALLOCATOR_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define FCCA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define FCCA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/fcca_pkg.sv @@
// Shared types, constants and helper functions of the FAT cluster chain allocator.
// Depends on nothing; imported by the allocator modules.
package fcca_pkg;

  // Port widths of the request and result fields.
  localparam int unsigned SECTOR_W = 12;
  localparam int unsigned CYL_W    = 4;
  localparam int unsigned TRK_W    = 3;
  localparam int unsigned SIT_W    = 6;

  // The used bitmap is kept in words of this many sectors.
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned WORD_IW = 5;
  localparam int unsigned MASK_W  = 2 * WORD_W;

  // Request kinds.
  localparam logic REQ_ALLOC  = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  typedef enum logic [13:0] {
    S_CLEAR    = 14'b00000000000001,
    S_IDLE     = 14'b00000000000010,
    S_LOOK     = 14'b00000000000100,
    S_LOOK_RD  = 14'b00000000001000,
    S_ADJ      = 14'b00000000010000,
    S_ADJ_CHK  = 14'b00000000100000,
    S_SCAN_RD  = 14'b00000001000000,
    S_SCAN_CHK = 14'b00000010000000,
    S_FIT      = 14'b00000100000000,
    S_LINK     = 14'b00001000000000,
    S_CLAIM    = 14'b00010000000000,
    S_CYL      = 14'b00100000000000,
    S_TRK      = 14'b01000000000000,
    S_DONE     = 14'b10000000000000
  } fcca_state_e;

  // Position of the lowest clear bit of a bitmap word.
  function automatic logic [WORD_IW-1:0] first_zero(input logic [WORD_W-1:0] w);
    logic [WORD_IW-1:0] pos;
    pos = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!w[i]) begin
        pos = WORD_IW'(i);
      end
    end
    return pos;
  endfunction

endpackage

@@ sv/fat_cluster_chain_allocator_core.sv @@
// Top level of the FAT cluster chain allocator: sequencer, tables and result register.
// Depends on fcca_pkg, fcca_ram, fcca_cmpsub and the assertion macro header.
//
//   channel  | handshake              | payload
//   ---------+------------------------+-----------------------------------------------
//   request  | in_valid_i / in_ready_o | req_type_i, is_first_i, is_last_i, lookup_sector_i
//   result   | out_valid_o / out_ready_i | start_sector_o, cylinder_o, track_o,
//            |                        | sector_in_track_o, full_res_o, next_sector_o,
//            |                        | end_of_chain_o, in_use_o
//
// A lookup reads the three tables and then loads the result register. An allocation
// tests the sector after the previous cluster, searches the bitmap if needed, claims the
// cluster one sector at a time and splits the start into cylinder and track by repeated
// compare-subtract steps. A first cluster skips the adjacency test and the link write, and a
// free-sector scan reads the bitmap one word at a time. After reset a clearing pass over
// every table entry blocks requests; a finished result waits for the output register.

`include "fat_cluster_chain_allocator_core_defines.svh"

module fat_cluster_chain_allocator_core #(
  parameter int unsigned SECTORS_PER_TRACK   = 60,
  parameter int unsigned TRACKS_PER_CYLINDER = 5,
  parameter int unsigned CYLINDERS           = 10,
  parameter int unsigned CLUSTER_SECTORS     = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          req_type_i,
  input  logic                          is_first_i,
  input  logic                          is_last_i,
  input  logic [fcca_pkg::SECTOR_W-1:0] lookup_sector_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [fcca_pkg::SECTOR_W-1:0] start_sector_o,
  output logic [fcca_pkg::CYL_W-1:0]    cylinder_o,
  output logic [fcca_pkg::TRK_W-1:0]    track_o,
  output logic [fcca_pkg::SIT_W-1:0]    sector_in_track_o,
  output logic                          full_res_o,
  output logic [fcca_pkg::SECTOR_W-1:0] next_sector_o,
  output logic                          end_of_chain_o,
  output logic                          in_use_o
);

  import fcca_pkg::*;

  // Geometry derived from the parameters.
  localparam int unsigned SPC       = SECTORS_PER_TRACK * TRACKS_PER_CYLINDER;
  localparam int unsigned TOTAL     = SPC * CYLINDERS;
  localparam int unsigned SW        = $clog2(TOTAL + CLUSTER_SECTORS);
  localparam int unsigned AW        = (TOTAL > 1) ? $clog2(TOTAL) : 1;
  localparam int unsigned NWORDS    = (TOTAL + WORD_W - 1) / WORD_W;
  localparam int unsigned WAW       = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int unsigned LAST_BITS = TOTAL - (NWORDS - 1) * WORD_W;
  localparam int unsigned CIW       = (CLUSTER_SECTORS > 1) ? $clog2(CLUSTER_SECTORS) : 1;
  localparam int unsigned CYW       = (CYLINDERS > 1) ? $clog2(CYLINDERS) : 1;
  localparam int unsigned TKW       = (TRACKS_PER_CYLINDER > 1) ?
                                      $clog2(TRACKS_PER_CYLINDER) : 1;

  // Bits of the last bitmap word that lie past the table read as used, so the
  // free-sector scan can never return them.
  localparam logic [WORD_W-1:0] PAD_MASK = (LAST_BITS == WORD_W) ? '0 :
                                           ~((WORD_W'(1) << LAST_BITS) - WORD_W'(1));
  localparam logic [MASK_W-1:0] CLUSTER_MASK =
      MASK_W'((65'd1 << CLUSTER_SECTORS) - 65'd1);

  // Control state.
  fcca_state_e         state_q, state_d;
  logic [AW-1:0]       clr_q, clr_d;
  logic [SW-1:0]       prev_q, prev_d;
  logic [WAW-1:0]      hint_q, hint_d;
  logic                out_valid_q, out_valid_d;

  // Working registers of the request in progress.
  logic                req_q, req_d;
  logic                first_q, first_d;
  logic                last_q, last_d;
  logic [SECTOR_W-1:0] look_q, look_d;
  logic [WAW-1:0]      scan_q, scan_d;
  logic [SW-1:0]       start_q, start_d;
  logic [WORD_W-1:0]   word_q, word_d;
  logic [CIW-1:0]      idx_q, idx_d;
  logic [SW-1:0]       acc_q, acc_d;
  logic [CYW-1:0]      cyl_q, cyl_d;
  logic [TKW-1:0]      trk_q, trk_d;
  logic                full_q, full_d;
  logic                lk_range_q, lk_range_d;
  logic [AW-1:0]       lk_next_q, lk_next_d;
  logic                lk_end_q, lk_end_d;
  logic                lk_use_q, lk_use_d;

  // Result register.
  logic [SECTOR_W-1:0] o_start_q, o_start_d;
  logic [CYL_W-1:0]    o_cyl_q, o_cyl_d;
  logic [TRK_W-1:0]    o_trk_q, o_trk_d;
  logic [SIT_W-1:0]    o_sit_q, o_sit_d;
  logic                o_full_q, o_full_d;
  logic [SECTOR_W-1:0] o_next_q, o_next_d;
  logic                o_end_q, o_end_d;
  logic                o_use_q, o_use_d;

  // Table ports.
  logic              nxt_we, nxt_re;
  logic [AW-1:0]     nxt_waddr, nxt_raddr, nxt_wdata, nxt_rdata;
  logic              end_we, end_re;
  logic [AW-1:0]     end_waddr, end_raddr;
  logic [0:0]        end_wdata, end_rdata;
  logic              used_we, used_re;
  logic [WAW-1:0]    used_waddr, used_raddr;
  logic [WORD_W-1:0] used_wdata, used_rdata;

  // Shared compare-subtract unit.
  logic [SW-1:0] div_b, div_diff;
  logic          div_ge;

  // Address helpers.
  logic [SW-1:0]     adj_sector, tail_sector, claim_sector, scan_sector;
  logic              adj_ok;
  logic [MASK_W-1:0] claim_mask;
  logic              claim_span;
  logic [WAW-1:0]    start_word, start_word_nxt;
  logic              fits;
  logic              load_out;

  assign adj_sector     = prev_q + SW'(CLUSTER_SECTORS);
  assign tail_sector    = prev_q + SW'(CLUSTER_SECTORS - 1);
  assign adj_ok         = (32'(adj_sector) < TOTAL);
  assign claim_sector   = start_q + SW'(idx_q);
  assign scan_sector    = SW'((32'(scan_q) << WORD_IW) | 32'(first_zero(used_rdata)));
  assign claim_mask     = CLUSTER_MASK << WORD_IW'(start_q);
  assign claim_span     = |claim_mask[MASK_W-1:WORD_W];
  assign start_word     = WAW'(start_q >> WORD_IW);
  assign start_word_nxt = start_word + WAW'(1);
  assign fits           = ((32'(start_q) + CLUSTER_SECTORS) <= TOTAL);
  assign div_b          = (state_q == S_CYL) ? SW'(SPC) : SW'(SECTORS_PER_TRACK);

  assign in_ready_o = (state_q == S_IDLE);
  assign load_out   = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  fcca_cmpsub #(
    .W(SW)
  ) u_cmpsub (
    .a_i   (acc_q),
    .b_i   (div_b),
    .ge_o  (div_ge),
    .diff_o(div_diff)
  );

  // Next-sector links, one entry per sector.
  fcca_ram #(
    .WIDTH(AW),
    .DEPTH(TOTAL)
  ) u_next_ram (
    .clk_i  (clk_i),
    .we_i   (nxt_we),
    .waddr_i(nxt_waddr),
    .wdata_i(nxt_wdata),
    .re_i   (nxt_re),
    .raddr_i(nxt_raddr),
    .rdata_o(nxt_rdata)
  );

  // End-of-chain marks, kept apart so a link write never disturbs a mark.
  fcca_ram #(
    .WIDTH(1),
    .DEPTH(TOTAL)
  ) u_end_ram (
    .clk_i  (clk_i),
    .we_i   (end_we),
    .waddr_i(end_waddr),
    .wdata_i(end_wdata),
    .re_i   (end_re),
    .raddr_i(end_raddr),
    .rdata_o(end_rdata)
  );

  // Used bitmap, one word per WORD_W sectors.
  fcca_ram #(
    .WIDTH(WORD_W),
    .DEPTH(NWORDS)
  ) u_used_ram (
    .clk_i  (clk_i),
    .we_i   (used_we),
    .waddr_i(used_waddr),
    .wdata_i(used_wdata),
    .re_i   (used_re),
    .raddr_i(used_raddr),
    .rdata_o(used_rdata)
  );

  // Sequencer. A request walks the states of its kind; an allocation tries the
  // sector after the previous cluster first, then scans the bitmap upward from the
  // hint word, below which every word is known to be full since sectors are never freed.
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    prev_d      = prev_q;
    hint_d      = hint_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    req_d       = req_q;
    first_d     = first_q;
    last_d      = last_q;
    look_d      = look_q;
    scan_d      = scan_q;
    start_d     = start_q;
    word_d      = word_q;
    idx_d       = idx_q;
    acc_d       = acc_q;
    cyl_d       = cyl_q;
    trk_d       = trk_q;
    full_d      = full_q;
    lk_range_d  = lk_range_q;
    lk_next_d   = lk_next_q;
    lk_end_d    = lk_end_q;
    lk_use_d    = lk_use_q;

    o_start_d = o_start_q;
    o_cyl_d   = o_cyl_q;
    o_trk_d   = o_trk_q;
    o_sit_d   = o_sit_q;
    o_full_d  = o_full_q;
    o_next_d  = o_next_q;
    o_end_d   = o_end_q;
    o_use_d   = o_use_q;

    nxt_we     = 1'b0;
    nxt_waddr  = AW'(claim_sector);
    nxt_wdata  = '0;
    nxt_re     = 1'b0;
    nxt_raddr  = AW'(look_q);
    end_we     = 1'b0;
    end_waddr  = AW'(claim_sector);
    end_wdata  = 1'b1;
    end_re     = 1'b0;
    end_raddr  = AW'(look_q);
    used_we    = 1'b0;
    used_waddr = start_word;
    used_wdata = word_q | claim_mask[WORD_W-1:0];
    used_re    = 1'b0;
    used_raddr = scan_q;

    case (state_q)
      S_CLEAR: begin
        nxt_we    = 1'b1;
        nxt_waddr = clr_q;
        nxt_wdata = '0;
        end_we    = 1'b1;
        end_waddr = clr_q;
        end_wdata = 1'b0;
        if (32'(clr_q) < NWORDS) begin
          used_we    = 1'b1;
          used_waddr = WAW'(clr_q);
          used_wdata = (32'(clr_q) == NWORDS - 1) ? PAD_MASK : '0;
        end
        if (clr_q == AW'(TOTAL - 1)) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + AW'(1);
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          req_d   = req_type_i;
          first_d = is_first_i;
          last_d  = is_last_i;
          look_d  = lookup_sector_i;
          full_d  = 1'b0;
          state_d = (req_type_i == REQ_LOOKUP) ? S_LOOK : S_ADJ;
        end
      end
      S_LOOK: begin
        nxt_re     = 1'b1;
        end_re     = 1'b1;
        used_re    = 1'b1;
        used_raddr = WAW'(look_q >> WORD_IW);
        lk_range_d = (32'(look_q) < TOTAL);
        state_d    = S_LOOK_RD;
      end
      S_LOOK_RD: begin
        lk_next_d = lk_range_q ? nxt_rdata : '0;
        lk_end_d  = lk_range_q & end_rdata[0];
        lk_use_d  = lk_range_q & used_rdata[WORD_IW'(look_q)];
        state_d   = S_DONE;
      end
      S_ADJ: begin
        if (!first_q && adj_ok) begin
          used_re    = 1'b1;
          used_raddr = WAW'(adj_sector >> WORD_IW);
          state_d    = S_ADJ_CHK;
        end else begin
          scan_d  = hint_q;
          state_d = S_SCAN_RD;
        end
      end
      S_ADJ_CHK: begin
        if (!used_rdata[WORD_IW'(adj_sector)]) begin
          start_d = adj_sector;
          word_d  = used_rdata;
          state_d = S_FIT;
        end else begin
          scan_d  = hint_q;
          state_d = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        used_re    = 1'b1;
        used_raddr = scan_q;
        state_d    = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (!(&used_rdata)) begin
          start_d = scan_sector;
          word_d  = used_rdata;
          hint_d  = scan_q;
          state_d = S_FIT;
        end else if (32'(scan_q) == NWORDS - 1) begin
          full_d  = 1'b1;
          state_d = S_DONE;
        end else begin
          scan_d  = scan_q + WAW'(1);
          state_d = S_SCAN_RD;
        end
      end
      S_FIT: begin
        if (fits) begin
          idx_d   = '0;
          state_d = first_q ? S_CLAIM : S_LINK;
        end else begin
          full_d  = 1'b1;
          state_d = S_DONE;
        end
      end
      S_LINK: begin
        if (32'(tail_sector) < TOTAL) begin
          nxt_we    = 1'b1;
          nxt_waddr = AW'(tail_sector);
          nxt_wdata = AW'(start_q);
        end
        state_d = S_CLAIM;
      end
      S_CLAIM: begin
        // One sector a cycle: chain it to the next one, and mark the last one as
        // the end of the file when asked.
        if (32'(idx_q) < CLUSTER_SECTORS - 1) begin
          nxt_we    = 1'b1;
          nxt_waddr = AW'(claim_sector);
          nxt_wdata = AW'(claim_sector + SW'(1));
        end
        if ((32'(idx_q) == CLUSTER_SECTORS - 1) && last_q) begin
          end_we    = 1'b1;
          end_waddr = AW'(claim_sector);
          end_wdata = 1'b1;
        end
        // The bitmap word read during the search is updated at index zero; a cluster that
        // crosses into the next word reads that word then and writes it at index one.
        if (idx_q == '0) begin
          used_we    = 1'b1;
          used_waddr = start_word;
          used_wdata = word_q | claim_mask[WORD_W-1:0];
          if (claim_span) begin
            used_re    = 1'b1;
            used_raddr = start_word_nxt;
          end
        end else if ((32'(idx_q) == 1) && claim_span) begin
          used_we    = 1'b1;
          used_waddr = start_word_nxt;
          used_wdata = used_rdata | claim_mask[MASK_W-1:WORD_W];
        end
        if (32'(idx_q) == CLUSTER_SECTORS - 1) begin
          prev_d  = start_q;
          acc_d   = start_q;
          cyl_d   = '0;
          trk_d   = '0;
          state_d = S_CYL;
        end else begin
          idx_d = idx_q + CIW'(1);
        end
      end
      S_CYL: begin
        if (div_ge) begin
          acc_d = div_diff;
          cyl_d = cyl_q + CYW'(1);
        end else begin
          state_d = S_TRK;
        end
      end
      S_TRK: begin
        if (div_ge) begin
          acc_d = div_diff;
          trk_d = trk_q + TKW'(1);
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (load_out) begin
          if ((req_q == REQ_ALLOC) && !full_q) begin
            o_start_d = SECTOR_W'(start_q);
            o_cyl_d   = CYL_W'(cyl_q);
            o_trk_d   = TRK_W'(trk_q);
            o_sit_d   = SIT_W'(acc_q);
          end else begin
            o_start_d = '0;
            o_cyl_d   = '0;
            o_trk_d   = '0;
            o_sit_d   = '0;
          end
          o_full_d = (req_q == REQ_ALLOC) & full_q;
          if (req_q == REQ_LOOKUP) begin
            o_next_d = SECTOR_W'(lk_next_q);
            o_end_d  = lk_end_q;
            o_use_d  = lk_use_q;
          end else begin
            o_next_d = '0;
            o_end_d  = 1'b0;
            o_use_d  = 1'b0;
          end
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      prev_q      <= '0;
      hint_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      prev_q      <= prev_d;
      hint_q      <= hint_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    first_q    <= first_d;
    last_q     <= last_d;
    look_q     <= look_d;
    scan_q     <= scan_d;
    start_q    <= start_d;
    word_q     <= word_d;
    idx_q      <= idx_d;
    acc_q      <= acc_d;
    cyl_q      <= cyl_d;
    trk_q      <= trk_d;
    full_q     <= full_d;
    lk_range_q <= lk_range_d;
    lk_next_q  <= lk_next_d;
    lk_end_q   <= lk_end_d;
    lk_use_q   <= lk_use_d;
    o_start_q  <= o_start_d;
    o_cyl_q    <= o_cyl_d;
    o_trk_q    <= o_trk_d;
    o_sit_q    <= o_sit_d;
    o_full_q   <= o_full_d;
    o_next_q   <= o_next_d;
    o_end_q    <= o_end_d;
    o_use_q    <= o_use_d;
  end

  assign out_valid_o       = out_valid_q;
  assign start_sector_o    = o_start_q;
  assign cylinder_o        = o_cyl_q;
  assign track_o           = o_trk_q;
  assign sector_in_track_o = o_sit_q;
  assign full_res_o        = o_full_q;
  assign next_sector_o     = o_next_q;
  assign end_of_chain_o    = o_end_q;
  assign in_use_o          = o_use_q;

  // A claimed cluster always lies wholly inside the table.
  `FCCA_ASSERT_IMP(a_claim_in_table, state_q == S_CLAIM, (32'(start_q) + CLUSTER_SECTORS) <= TOTAL, "cluster claim runs past the table")
  // The bitmap scan never addresses a word beyond the bitmap.
  `FCCA_ASSERT_IMP(a_scan_in_range, state_q == S_SCAN_RD, 32'(scan_q) < NWORDS, "bitmap scan left the bitmap")
  // A new result appears only after the sequencer has finished a request.
  `FCCA_ASSERT_NXT(a_result_from_done, state_q != S_DONE, !$rose(out_valid_o), "result raised outside the done state")

endmodule

@@ sv/fcca_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; used for every table of the allocator.
module fcca_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

@@ sv/fcca_cmpsub.sv @@
// Shared compare-and-subtract unit of the allocator.
// Depends on nothing; one step of the repeated-subtraction address split.
module fcca_cmpsub #(
  parameter int unsigned W = 12
) (
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  output logic         ge_o,
  output logic [W-1:0] diff_o
);

  assign ge_o   = (a_i >= b_i);
  assign diff_o = a_i - b_i;

endmodule
